// ===== rtl/adc_temperature_seven_segment_core_assert.svh =====
// Assertion macros used by the checker file of the temperature display core.
`ifndef ADC_TEMPERATURE_SEVEN_SEGMENT_CORE_ASSERT_SVH
`define ADC_TEMPERATURE_SEVEN_SEGMENT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ATSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ATSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/atss_pkg.sv =====
// Shared constants, digit codes and helpers of the temperature display core.
`timescale 1ns / 1ps
package atss_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned FILT_W          = 12;
  localparam int unsigned THR_W           = 14;
  localparam int unsigned SEG_W           = 8;
  localparam int unsigned T_W             = 14;

  localparam logic [THR_W-1:0] THR_RESET = 14'd300;

  // FIR taps, symmetric
  localparam int unsigned TAP_OUTER  = 10;
  localparam int unsigned TAP_INNER  = 15;
  localparam int unsigned TAP_CENTER = 50;
  localparam longint unsigned FIR_DIV = 100;

  // tenths conversion: (MUL*v + OFF) / DIV
  localparam longint unsigned C_MUL = 50;
  localparam longint unsigned C_OFF = 3124962;
  localparam longint unsigned C_DIV = 12500;
  localparam longint unsigned F_MUL = 450;
  localparam longint unsigned F_OFF = 48124658;
  localparam longint unsigned F_DIV = 62500;

  localparam longint unsigned TENTHS_MAX = 9999;

  localparam logic [SEG_W-1:0] SEG_BLANK   = 8'hFF;
  localparam logic [SEG_W-1:0] SEG_DP_MASK = 8'h7F;

  // active-low segment code, bit0 = A, bit7 = point
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h98;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // low four bits of 10*x
  function automatic logic [3:0] times10_lo(input logic [3:0] x);
    logic [3:0] r;
    r = {x[0], 3'b000} + {x[2:0], 1'b0};
    return r;
  endfunction

endpackage

// ===== rtl/adc_temperature_seven_segment_core.sv =====
// Filtered ADC temperature to four-digit seven-segment codes, six-stage pipeline.
// A request moves through the stage registers in order and is held wherever an output stall stops it.
// Throughput: one request per cycle; only the output handshake can stall the pipe,
// and empty stages collapse, so a request is taken whenever any slot ahead is free.
// Reset: asynchronous, active low; clears the delay line, valid bits, threshold = 300.
`timescale 1ns / 1ps
module adc_temperature_seven_segment_core #(
  parameter int unsigned SAMPLE_BITS = atss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic                         sample_ok_i,
  input  logic                         unit_fahrenheit_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [atss_pkg::FILT_W-1:0]  filtered_value_o,
  output logic [atss_pkg::SEG_W-1:0]   seg_thousands_o,
  output logic [atss_pkg::SEG_W-1:0]   seg_hundreds_o,
  output logic [atss_pkg::SEG_W-1:0]   seg_ones_o,
  output logic [atss_pkg::SEG_W-1:0]   seg_tenths_o,
  output logic                         over_temperature_o,
  output logic                         display_valid_o,
  // threshold write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [atss_pkg::THR_W-1:0]   cfg_data_i
);

  // Pipeline:
  //   stage 0  FIR sum of the new sample and the delay line (shift-add taps)
  //   stage 1  divide by 100 through a reciprocal multiply
  //   stage 2  Celsius / Fahrenheit numerators, alarm compare against threshold
  //   stage 3  divide numerators through reciprocal multiplies, select, saturate
  //   stage 4  tenths value divided by 10, 100 and 1000 (reciprocal multiplies)
  //   stage 5  digit extraction in 4-bit arithmetic, segment lookup, output register
  // Every constant division uses m = ceil(2^k / d) with k = n + clog2(d),
  // exact for all n-bit dividends.

  localparam int unsigned STAGES = 6;
  localparam int unsigned T_W    = atss_pkg::T_W;

  localparam longint unsigned SMAX = (64'd1 << SAMPLE_BITS) - 64'd1;

  // FIR sum < 128 * 2^SAMPLE_BITS
  localparam int unsigned SUM_W  = SAMPLE_BITS + 7;
  localparam int unsigned K100   = SUM_W + $clog2(atss_pkg::FIR_DIV);
  localparam longint unsigned M100 =
    ((64'd1 << K100) + atss_pkg::FIR_DIV - 64'd1) / atss_pkg::FIR_DIV;
  localparam int unsigned P100_W = K100 + SAMPLE_BITS;

  // Celsius numerator and its reciprocal
  localparam longint unsigned CN_MAX = atss_pkg::C_MUL * SMAX + atss_pkg::C_OFF;
  localparam int unsigned CN_W = $clog2(CN_MAX + 64'd1);
  localparam int unsigned KC   = CN_W + $clog2(atss_pkg::C_DIV);
  localparam longint unsigned MC =
    ((64'd1 << KC) + atss_pkg::C_DIV - 64'd1) / atss_pkg::C_DIV;
  localparam int unsigned QC_W = CN_W - $clog2(atss_pkg::C_DIV) + 2;
  localparam int unsigned PC_W = KC + QC_W;

  // Fahrenheit numerator and its reciprocal
  localparam longint unsigned FN_MAX = atss_pkg::F_MUL * SMAX + atss_pkg::F_OFF;
  localparam int unsigned FN_W = $clog2(FN_MAX + 64'd1);
  localparam int unsigned KF   = FN_W + $clog2(atss_pkg::F_DIV);
  localparam longint unsigned MF =
    ((64'd1 << KF) + atss_pkg::F_DIV - 64'd1) / atss_pkg::F_DIV;
  localparam int unsigned QF_W = FN_W - $clog2(atss_pkg::F_DIV) + 2;
  localparam int unsigned PF_W = KF + QF_W;

  localparam int unsigned EXT_W = QC_W + QF_W + T_W;
  localparam int unsigned CMP_W = CN_W + atss_pkg::THR_W + $clog2(atss_pkg::C_DIV);

  // digit split of the 14-bit tenths value
  localparam longint unsigned D10   = 10;
  localparam longint unsigned D100  = 100;
  localparam longint unsigned D1000 = 1000;
  localparam int unsigned K10   = T_W + $clog2(D10);
  localparam int unsigned K100D = T_W + $clog2(D100);
  localparam int unsigned K1000 = T_W + $clog2(D1000);
  localparam longint unsigned M10   = ((64'd1 << K10) + D10 - 64'd1) / D10;
  localparam longint unsigned M100D = ((64'd1 << K100D) + D100 - 64'd1) / D100;
  localparam longint unsigned M1000 = ((64'd1 << K1000) + D1000 - 64'd1) / D1000;
  localparam int unsigned P10_W   = K10 + T_W - $clog2(D10) + 2;
  localparam int unsigned P100D_W = K100D + T_W - $clog2(D100) + 2;
  localparam int unsigned P1000_W = K1000 + T_W - $clog2(D1000) + 2;

  // ---------------------------------------------------------------------------
  // Handshake: a stage advances when it is empty or the stage ahead advances.
  // ---------------------------------------------------------------------------
  logic [STAGES-1:0] vld_q, vld_d;
  logic [STAGES-1:0] adv;
  logic              in_acc;

  always_comb begin
    adv[STAGES-1] = !vld_q[STAGES-1] || out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign in_ready_o  = adv[0];
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = vld_q[STAGES-1];
  assign cfg_ready_o = 1'b1;

  logic [SAMPLE_BITS-1:0]       dly_q [4];
  logic [atss_pkg::THR_W-1:0]   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      for (int k = 0; k < 4; k++) begin
        dly_q[k] <= '0;
      end
      thr_q <= atss_pkg::THR_RESET;
    end else begin
      vld_q <= vld_d;
      if (in_acc) begin
        // newest first
        dly_q[3] <= dly_q[2];
        dly_q[2] <= dly_q[1];
        dly_q[1] <= dly_q[0];
        dly_q[0] <= sample_i;
      end
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: symmetric FIR sum
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_d, sum_q;
  logic             ok0_q, fahr0_q;

  assign sum_d = SUM_W'(atss_pkg::TAP_OUTER) * (SUM_W'(sample_i) + SUM_W'(dly_q[3]))
               + SUM_W'(atss_pkg::TAP_INNER) * (SUM_W'(dly_q[0]) + SUM_W'(dly_q[2]))
               + SUM_W'(atss_pkg::TAP_CENTER) * SUM_W'(dly_q[1]);

  // ---------------------------------------------------------------------------
  // Stage 1: floor(sum / 100)
  // ---------------------------------------------------------------------------
  logic [P100_W-1:0]      p100;
  logic [SAMPLE_BITS-1:0] v1_d, v1_q;
  logic                   ok1_q, fahr1_q;

  assign p100 = P100_W'(sum_q) * P100_W'(M100);
  assign v1_d = p100[K100 +: SAMPLE_BITS];

  // ---------------------------------------------------------------------------
  // Stage 2: numerators and alarm
  // ---------------------------------------------------------------------------
  logic [CN_W-1:0]        cnum_d, cnum_q;
  logic [FN_W-1:0]        fnum_d, fnum_q;
  logic                   over2_d, over2_q;
  logic [SAMPLE_BITS-1:0] v2_q;
  logic                   ok2_q, fahr2_q;

  assign cnum_d  = CN_W'(atss_pkg::C_MUL) * CN_W'(v1_q) + CN_W'(atss_pkg::C_OFF);
  assign fnum_d  = FN_W'(atss_pkg::F_MUL) * FN_W'(v1_q) + FN_W'(atss_pkg::F_OFF);
  // alarm on exact Celsius: strictly above threshold
  assign over2_d = CMP_W'(cnum_d) > (CMP_W'(thr_q) * CMP_W'(atss_pkg::C_DIV));

  // ---------------------------------------------------------------------------
  // Stage 3: tenths, unit select, saturation
  // ---------------------------------------------------------------------------
  logic [PC_W-1:0]        pc;
  logic [PF_W-1:0]        pf;
  logic [EXT_W-1:0]       tq;
  logic [T_W-1:0]         t3_d, t3_q;
  logic                   over3_q, ok3_q;
  logic [SAMPLE_BITS-1:0] v3_q;

  assign pc   = PC_W'(cnum_q) * PC_W'(MC);
  assign pf   = PF_W'(fnum_q) * PF_W'(MF);
  assign tq   = fahr2_q ? EXT_W'(pf[KF +: QF_W]) : EXT_W'(pc[KC +: QC_W]);
  assign t3_d = (tq > EXT_W'(atss_pkg::TENTHS_MAX)) ? T_W'(atss_pkg::TENTHS_MAX)
                                                   : tq[T_W-1:0];

  // ---------------------------------------------------------------------------
  // Stage 4: quotients by 10, 100, 1000; only low nibbles are needed later
  // ---------------------------------------------------------------------------
  logic [P10_W-1:0]       p10;
  logic [P100D_W-1:0]     p100d;
  logic [P1000_W-1:0]     p1000;
  logic [3:0]             q10_q, q100_q, q1000_q, tlo_q;
  logic                   ge100_q, ge1000_q, over4_q, ok4_q;
  logic [SAMPLE_BITS-1:0] v4_q;

  assign p10   = P10_W'(t3_q) * P10_W'(M10);
  assign p100d = P100D_W'(t3_q) * P100D_W'(M100D);
  assign p1000 = P1000_W'(t3_q) * P1000_W'(M1000);

  // ---------------------------------------------------------------------------
  // Stage 5: digits (each below ten, so mod-16 math is exact) and segments
  // ---------------------------------------------------------------------------
  logic [3:0] d_tenths, d_ones, d_tens, d_hund;
  logic [SAMPLE_BITS+atss_pkg::FILT_W-1:0] v_ext;

  assign d_tenths = tlo_q  - atss_pkg::times10_lo(q10_q);
  assign d_ones   = q10_q  - atss_pkg::times10_lo(q100_q);
  assign d_tens   = q100_q - atss_pkg::times10_lo(q1000_q);
  assign d_hund   = q1000_q;
  assign v_ext    = {{atss_pkg::FILT_W{1'b0}}, v4_q};

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sum_q   <= sum_d;
      ok0_q   <= sample_ok_i;
      fahr0_q <= unit_fahrenheit_i;
    end
    if (adv[1]) begin
      v1_q    <= v1_d;
      ok1_q   <= ok0_q;
      fahr1_q <= fahr0_q;
    end
    if (adv[2]) begin
      cnum_q  <= cnum_d;
      fnum_q  <= fnum_d;
      over2_q <= over2_d;
      v2_q    <= v1_q;
      ok2_q   <= ok1_q;
      fahr2_q <= fahr1_q;
    end
    if (adv[3]) begin
      t3_q    <= t3_d;
      over3_q <= over2_q;
      v3_q    <= v2_q;
      ok3_q   <= ok2_q;
    end
    if (adv[4]) begin
      q10_q    <= p10[K10 +: 4];
      q100_q   <= p100d[K100D +: 4];
      q1000_q  <= p1000[K1000 +: 4];
      tlo_q    <= t3_q[3:0];
      ge100_q  <= t3_q >= T_W'(D100);
      ge1000_q <= t3_q >= T_W'(D1000);
      over4_q  <= over3_q;
      v4_q     <= v3_q;
      ok4_q    <= ok3_q;
    end
    if (adv[5]) begin
      filtered_value_o   <= v_ext[atss_pkg::FILT_W-1:0];
      seg_thousands_o    <= ge1000_q ? atss_pkg::seg_code(d_hund) : atss_pkg::SEG_BLANK;
      seg_hundreds_o     <= ge100_q ? atss_pkg::seg_code(d_tens) : atss_pkg::SEG_BLANK;
      // point lit on the ones digit
      seg_ones_o         <= atss_pkg::seg_code(d_ones) & atss_pkg::SEG_DP_MASK;
      seg_tenths_o       <= atss_pkg::seg_code(d_tenths);
      over_temperature_o <= over4_q;
      display_valid_o    <= ok4_q;
    end
  end

endmodule

// ===== rtl/atss_checker.sv =====
// Port-level checker of the temperature display core, with its bind.
`timescale 1ns / 1ps
`include "adc_temperature_seven_segment_core_assert.svh"
module atss_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [atss_pkg::SEG_W-1:0] seg_thousands_o,
  input logic [atss_pkg::SEG_W-1:0] seg_hundreds_o,
  input logic [atss_pkg::SEG_W-1:0] seg_ones_o,
  input logic [atss_pkg::SEG_W-1:0] seg_tenths_o,
  input logic                       display_valid_o
);

  // stalled result holds
  `ATSS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(seg_ones_o) && $stable(seg_tenths_o) && $stable(display_valid_o))

  // empty output slot means the pipe can take a request
  `ATSS_ASSERT_IMP(a_ready_when_out_empty, !out_valid_o, in_ready_o)

  // decimal point always lit on the ones digit
  `ATSS_ASSERT_IMP(a_ones_point, out_valid_o, !seg_ones_o[atss_pkg::SEG_W-1])

  // leading blanking: a shown thousands digit implies a shown hundreds digit
  `ATSS_ASSERT_IMP(a_blank_order, out_valid_o && (seg_thousands_o != atss_pkg::SEG_BLANK), seg_hundreds_o != atss_pkg::SEG_BLANK)

endmodule

bind adc_temperature_seven_segment_core atss_checker u_atss_checker (.*);

// ===== tb/sv/tb_adc_temperature_seven_segment_core.sv =====
// Self-checking testbench for the filtered temperature seven-segment core.
`timescale 1ns / 1ps
module tb_adc_temperature_seven_segment_core;

  // Run-time guard on the total simulated time.
  localparam longint unsigned RUN_LIMIT_NS = 64'd2_000_000;
  localparam int unsigned     MAX_GAP      = 18;
  localparam int unsigned     DRAIN_CYCLES = 3000;
  localparam int unsigned     SETTLE_CYCLES = 20;

  // Active-low digit patterns 0..9, digit d sits at bits [8d +: 8].
  localparam logic [79:0] DIGIT_SEGS = {
    8'h98, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };
  localparam logic [7:0] BLANK_DIGIT = 8'hFF;
  localparam logic [7:0] POINT_ON    = 8'h7F;  // AND mask, clears bit7 (point lit)

  // Display conversion in exact integers: tenths = (mul*v + off) / div.
  localparam int unsigned CEL_MUL = 50;
  localparam int unsigned CEL_OFF = 3124962;
  localparam int unsigned CEL_DIV = 12500;
  localparam int unsigned FAH_MUL = 450;
  localparam int unsigned FAH_OFF = 48124658;
  localparam int unsigned FAH_DIV = 62500;
  localparam int unsigned TENTHS_CAP = 9999;
  localparam logic [13:0] ALARM_RESET = 14'd300;

  // Shapes of the sample streams used by the random traffic.
  typedef enum logic [1:0] {
    SHAPE_LEVEL,
    SHAPE_RAMP,
    SHAPE_NOISE,
    SHAPE_EXTREME
  } wave_shape_e;

  // Unit selection per burst.
  typedef enum logic [1:0] {
    UNITS_CELSIUS,
    UNITS_FAHRENHEIT,
    UNITS_MIXED
  } unit_mix_e;

  typedef struct packed {
    logic [11:0] filt;
    logic [7:0]  thou;
    logic [7:0]  hund;
    logic [7:0]  ones;
    logic [7:0]  tenths;
    logic        alarm;
    logic        disp;
  } readout_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [11:0]                  sample_i;
  logic                         sample_ok_i;
  logic                         unit_fahrenheit_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [atss_pkg::FILT_W-1:0]  filtered_value_o;
  logic [atss_pkg::SEG_W-1:0]   seg_thousands_o;
  logic [atss_pkg::SEG_W-1:0]   seg_hundreds_o;
  logic [atss_pkg::SEG_W-1:0]   seg_ones_o;
  logic [atss_pkg::SEG_W-1:0]   seg_tenths_o;
  logic                         over_temperature_o;
  logic                         display_valid_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [atss_pkg::THR_W-1:0]   cfg_data_i;

  // Predictor state: FIR delay line (newest first) and alarm threshold.
  logic [11:0] fir_taps [4];
  logic [13:0] alarm_limit;

  readout_t    pending_readouts [$];
  int unsigned items_sent;
  int unsigned readouts_seen;
  int unsigned mismatch_count;

  // Idle switches for the request side and the result side.
  bit          in_idle_on;
  bit          out_idle_on;

  adc_temperature_seven_segment_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sample_i           (sample_i),
    .sample_ok_i        (sample_ok_i),
    .unit_fahrenheit_i  (unit_fahrenheit_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .filtered_value_o   (filtered_value_o),
    .seg_thousands_o    (seg_thousands_o),
    .seg_hundreds_o     (seg_hundreds_o),
    .seg_ones_o         (seg_ones_o),
    .seg_tenths_o       (seg_tenths_o),
    .over_temperature_o (over_temperature_o),
    .display_valid_o    (display_valid_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT_NS);
    $display("** adc_temperature_seven_segment_core: FAILED **");
    $finish;
  end

  function automatic int unsigned draw_gap(input bit enabled);
    return enabled ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // Digit d of the table, active low.
  function automatic logic [7:0] digit_pattern(input int unsigned d);
    return DIGIT_SEGS[d*8 +: 8];
  endfunction

  // Next display readout for one sample; advances the delay line.
  task automatic predict_readout(input logic [11:0] x, input logic ok, input logic fahr,
                                 output readout_t r);
    int unsigned acc;
    int unsigned filt;
    int unsigned cnum;
    int unsigned tenths;
    acc = 10 * (int'(x) + int'(fir_taps[3]))
        + 15 * (int'(fir_taps[0]) + int'(fir_taps[2]))
        + 50 * int'(fir_taps[1]);
    filt = acc / 100;
    fir_taps[3] = fir_taps[2];
    fir_taps[2] = fir_taps[1];
    fir_taps[1] = fir_taps[0];
    fir_taps[0] = x;

    cnum = CEL_MUL * filt + CEL_OFF;
    if (fahr) tenths = (FAH_MUL * filt + FAH_OFF) / FAH_DIV;
    else      tenths = cnum / CEL_DIV;
    if (tenths > TENTHS_CAP) tenths = TENTHS_CAP;

    r.filt   = filt[11:0];
    // leading digits go dark, ones and tenths always shown
    r.thou   = (tenths >= 1000) ? digit_pattern((tenths / 1000) % 10) : BLANK_DIGIT;
    r.hund   = (tenths >= 100) ? digit_pattern((tenths / 100) % 10) : BLANK_DIGIT;
    r.ones   = digit_pattern((tenths / 10) % 10) & POINT_ON;
    r.tenths = digit_pattern(tenths % 10);
    // alarm uses the exact Celsius numerator, not the truncated tenths
    r.alarm  = (cnum > int'(alarm_limit) * CEL_DIV);
    r.disp   = ok;
  endtask

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t result %0d: %s expected %0h got %0h",
               $realtime, readouts_seen, what, want, got);
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want !== got) note_mismatch(what, want, got);
  endfunction

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    readout_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readouts.size() == 0) begin
        note_mismatch("unexpected result, filtered_value", 0, filtered_value_o);
      end else begin
        want = pending_readouts.pop_front();
        check_field("filtered_value", want.filt, filtered_value_o);
        check_field("seg_thousands", want.thou, seg_thousands_o);
        check_field("seg_hundreds", want.hund, seg_hundreds_o);
        check_field("seg_ones", want.ones, seg_ones_o);
        check_field("seg_tenths", want.tenths, seg_tenths_o);
        check_field("over_temperature", want.alarm, over_temperature_o);
        check_field("display_valid", want.disp, display_valid_o);
      end
      readouts_seen++;
    end
  end

  // Result side: a fresh stall is drawn for every result taken. Ready is only
  // lowered on a step where it is not raised again.
  initial begin : result_sink
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = draw_gap(out_idle_on);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // One sample request; returns at the edge that accepted it. Valid stays up
  // across back-to-back requests when no gap is drawn.
  task automatic send_sample(input logic [11:0] value, input logic ok, input logic fahr);
    int unsigned gap;
    readout_t want;
    gap = draw_gap(in_idle_on);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sample_i          <= value;
    sample_ok_i       <= ok;
    unit_fahrenheit_i <= fahr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_readout(value, ok, fahr, want);
    pending_readouts.push_back(want);
    items_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Every request yields one result, so an empty queue means an empty pipe.
  task automatic wait_idle();
    while (pending_readouts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [13:0] value);
    end_burst();
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    alarm_limit = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly around the live Celsius span (24.9 to 26.6 degrees), sometimes extremes.
  function automatic logic [13:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return 14'd0;
      1:       return 14'h3FFF;
      2:       return 14'd9999;
      default: return 14'($urandom_range(245, 270));
    endcase
  endfunction

  // Directed: empty delay line, a single full-scale impulse walking through
  // every tap, a full-scale plateau, alternating bit patterns, both units.
  task automatic test_filter_extremes();
    int k;
    send_sample(12'd0, 1'b1, 1'b0);
    send_sample(12'd0, 1'b1, 1'b1);
    send_sample(12'hFFF, 1'b1, 1'b0);
    for (k = 0; k < 4; k++) send_sample(12'd0, 1'b1, k[0]);
    for (k = 0; k < 5; k++) send_sample(12'hFFF, 1'b1, k[0]);
    send_sample(12'hAAA, 1'b1, 1'b0);
    send_sample(12'h555, 1'b1, 1'b1);
    end_burst();
  endtask

  // Failed reads still shift the sample in; only display_valid drops.
  task automatic test_failed_read();
    send_sample(12'hFFF, 1'b0, 1'b1);
    send_sample(12'd0, 1'b0, 1'b0);
    send_sample(12'h800, 1'b0, 1'b1);
    send_sample(12'h7FF, 1'b0, 1'b0);
    end_burst();
  endtask

  // Threshold extremes and values at the edges and middle of the reachable Celsius span,
  // each followed by a coarse ramp that sweeps the filtered value.
  task automatic test_alarm_threshold();
    logic [13:0] limits [6];
    int          i;
    int          k;
    int unsigned lvl;
    limits = '{14'd0, 14'h3FFF, 14'd9999, 14'd249, 14'd266, 14'd257};
    for (i = 0; i < 6; i++) begin
      in_idle_on  = i[0];
      out_idle_on = i[1];
      write_threshold(limits[i]);
      lvl = $urandom_range(0, 200);
      for (k = 0; k < 24; k++) begin
        send_sample(lvl[11:0], 1'b1, 1'($urandom_range(0, 1)));
        lvl = (lvl + 180 > 4095) ? 4095 : lvl + 180;
      end
    end
    end_burst();
  endtask

  // Bursts of shaped traffic with a new threshold and idle mix per burst.
  task automatic test_random_traffic(input int unsigned target);
    wave_shape_e shape;
    unit_mix_e   units;
    int          lvl;
    int          step;
    int          noisy;
    int unsigned burst_len;
    int unsigned k;
    logic [11:0] value;
    logic        fahr;
    while (items_sent < target) begin
      write_threshold(pick_threshold());
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      shape       = wave_shape_e'($urandom_range(0, 3));
      units       = unit_mix_e'($urandom_range(0, 2));
      burst_len   = $urandom_range(20, 80);
      lvl         = $urandom_range(0, 4095);
      step        = $urandom_range(1, 64);
      if ($urandom_range(0, 1)) step = -step;
      for (k = 0; k < burst_len; k++) begin
        case (shape)
          SHAPE_LEVEL: begin
            noisy = lvl + $urandom_range(0, 32) - 16;
            if (noisy < 0) noisy = 0;
            if (noisy > 4095) noisy = 4095;
            value = noisy[11:0];
          end
          SHAPE_RAMP: begin
            value = lvl[11:0];
            lvl   = (lvl + step) & 12'hFFF;  // wraps across the full scale
          end
          SHAPE_NOISE: value = 12'($urandom_range(0, 4095));
          default: begin
            case ($urandom_range(0, 3))
              0:       value = 12'd0;
              1:       value = 12'd1;
              2:       value = 12'hFFE;
              default: value = 12'hFFF;
            endcase
          end
        endcase
        case (units)
          UNITS_CELSIUS:    fahr = 1'b0;
          UNITS_FAHRENHEIT: fahr = 1'b1;
          default:          fahr = 1'($urandom_range(0, 1));
        endcase
        send_sample(value, ($urandom_range(0, 7) != 0), fahr);
      end
    end
    end_burst();
  endtask

  initial begin : stimulus
    int unsigned waited;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    sample_i          = '0;
    sample_ok_i       = 1'b0;
    unit_fahrenheit_i = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    fir_taps          = '{12'd0, 12'd0, 12'd0, 12'd0};
    alarm_limit       = ALARM_RESET;
    items_sent        = 0;
    readouts_seen     = 0;
    mismatch_count    = 0;
    in_idle_on        = 1'b0;
    out_idle_on       = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_filter_extremes();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    test_failed_read();
    test_alarm_threshold();
    test_random_traffic(1150);

    // Bounded drain, then a settling wait to catch any stray result.
    waited = 0;
    while (pending_readouts.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_readouts.size() != 0)
      $display("%0d expected results never arrived", pending_readouts.size());

    if (mismatch_count == 0 && pending_readouts.size() == 0) begin
      $display("** adc_temperature_seven_segment_core: PASSED **");
    end else begin
      $display("** adc_temperature_seven_segment_core: FAILED **");
    end
    $finish;
  end

endmodule
